### hw/rtl/hs_pkg.sv
// heap_sorter package: payload types, microcode program and compare helper
package hs_pkg;

  localparam int HS_DEPTH = 64;
  localparam int HS_VW    = 32;

  typedef struct packed {
    logic signed [HS_VW-1:0] value;
    logic                    last;
  } hs_in_t;

  typedef struct packed {
    logic signed [HS_VW-1:0] sorted_value;
    logic                    end_of_batch;
    logic                    overflow;
  } hs_out_t;

  typedef logic [4:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_COLLECT,
    OP_INIT,
    OP_BSTART,
    OP_XRD0,
    OP_XRD1,
    OP_XW0,
    OP_XW1,
    OP_SDLOAD,
    OP_CMPL,
    OP_CMPR,
    OP_WNODE,
    OP_SWAP,
    OP_OSTART,
    OP_OEMIT,
    OP_ODONE
  } hs_op_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NOT_LAST_FIRE,
    C_I_ZERO,
    C_N_LE1,
    C_N_GT2,
    C_PH_BUILD,
    C_NO_LC,
    C_NO_RC,
    C_PICK_EQ_NODE,
    C_HAS_LC_PICK,
    C_EMIT_STAY
  } hs_cond_t;

  typedef struct packed {
    hs_op_t   op;
    hs_cond_t cond;
    step_t    target;
  } hs_ctrl_t;

  typedef struct packed {
    logic last_fire;
    logic i_zero;
    logic n_le1;
    logic n_gt2;
    logic ph_extract;
    logic no_lc;
    logic no_rc;
    logic pick_eq_node;
    logic has_lc_pick;
    logic out_free;
    logic k_last;
  } hs_flags_t;

  // program step addresses
  localparam step_t S_COLLECT = 5'd0;
  localparam step_t S_INIT    = 5'd1;
  localparam step_t S_BTEST   = 5'd2;
  localparam step_t S_BSTART  = 5'd3;
  localparam step_t S_XTEST   = 5'd4;
  localparam step_t S_XRD0    = 5'd5;
  localparam step_t S_XRD1    = 5'd6;
  localparam step_t S_XW0     = 5'd7;
  localparam step_t S_XW1     = 5'd8;
  localparam step_t S_SDEND   = 5'd9;
  localparam step_t S_SDBACK  = 5'd10;
  localparam step_t S_SDLOAD  = 5'd11;
  localparam step_t S_SDCMPL  = 5'd12;
  localparam step_t S_SDCMPR  = 5'd13;
  localparam step_t S_SDCHK   = 5'd14;
  localparam step_t S_SDSWAP  = 5'd15;
  localparam step_t S_SDRET   = 5'd16;
  localparam step_t S_OSTART  = 5'd17;
  localparam step_t S_OEMIT   = 5'd18;
  localparam step_t S_ODONE   = 5'd19;

  function automatic hs_ctrl_t hs_ucode(input step_t s);
    hs_ctrl_t w;
    case (s)
      S_COLLECT: w = '{OP_COLLECT, C_NOT_LAST_FIRE, S_COLLECT};
      S_INIT:    w = '{OP_INIT,    C_NONE,          S_COLLECT};
      S_BTEST:   w = '{OP_NOP,     C_I_ZERO,        S_XTEST};
      S_BSTART:  w = '{OP_BSTART,  C_ALWAYS,        S_SDLOAD};
      S_XTEST:   w = '{OP_NOP,     C_N_LE1,         S_OSTART};
      S_XRD0:    w = '{OP_XRD0,    C_NONE,          S_COLLECT};
      S_XRD1:    w = '{OP_XRD1,    C_NONE,          S_COLLECT};
      S_XW0:     w = '{OP_XW0,     C_NONE,          S_COLLECT};
      S_XW1:     w = '{OP_XW1,     C_N_GT2,         S_SDCMPL};
      S_SDEND:   w = '{OP_NOP,     C_PH_BUILD,      S_BTEST};
      S_SDBACK:  w = '{OP_NOP,     C_ALWAYS,        S_XTEST};
      S_SDLOAD:  w = '{OP_SDLOAD,  C_NO_LC,         S_SDEND};
      S_SDCMPL:  w = '{OP_CMPL,    C_NO_RC,         S_SDCHK};
      S_SDCMPR:  w = '{OP_CMPR,    C_NONE,          S_COLLECT};
      S_SDCHK:   w = '{OP_WNODE,   C_PICK_EQ_NODE,  S_SDEND};
      S_SDSWAP:  w = '{OP_SWAP,    C_HAS_LC_PICK,   S_SDCMPL};
      S_SDRET:   w = '{OP_NOP,     C_ALWAYS,        S_SDEND};
      S_OSTART:  w = '{OP_OSTART,  C_NONE,          S_COLLECT};
      S_OEMIT:   w = '{OP_OEMIT,   C_EMIT_STAY,     S_OEMIT};
      S_ODONE:   w = '{OP_ODONE,   C_ALWAYS,        S_COLLECT};
      default:   w = '{OP_NOP,     C_ALWAYS,        S_COLLECT};
    endcase
    return w;
  endfunction

  // true if a belongs above b in the heap
  function automatic logic hs_ranks_above(input logic signed [HS_VW-1:0] a,
                                          input logic signed [HS_VW-1:0] b,
                                          input logic min_heap);
    return min_heap ? (a < b) : (a > b);
  endfunction

endpackage

### hw/rtl/hs_seq.sv
// heap_sorter microcode sequencer: step counter, program table, branch select
module hs_seq
  import hs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  hs_flags_t flags,
  output hs_ctrl_t  ctrl
);

  step_t step_r, step_nxt;
  logic  take;

  assign ctrl = hs_ucode(step_r);

  always_comb begin
    case (ctrl.cond)
      C_NONE:          take = 1'b0;
      C_ALWAYS:        take = 1'b1;
      C_NOT_LAST_FIRE: take = !flags.last_fire;
      C_I_ZERO:        take = flags.i_zero;
      C_N_LE1:         take = flags.n_le1;
      C_N_GT2:         take = flags.n_gt2;
      C_PH_BUILD:      take = !flags.ph_extract;
      C_NO_LC:         take = flags.no_lc;
      C_NO_RC:         take = flags.no_rc;
      C_PICK_EQ_NODE:  take = flags.pick_eq_node;
      C_HAS_LC_PICK:   take = flags.has_lc_pick;
      C_EMIT_STAY:     take = !(flags.out_free && flags.k_last);
      default:         take = 1'b1;
    endcase
    step_nxt = take ? ctrl.target : step_t'(step_r + 5'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_COLLECT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### hw/rtl/heap_sorter.sv
// heap_sorter top level: element store, heap datapath and output register
// While collecting, values are taken one beat per cycle into a DEPTH-entry
// store; the beat with last set closes the batch (values past DEPTH are
// dropped and flagged). The store is then heap sorted in place under a
// microcoded sequencer that uses one store read port (registered) and one
// write port; after the sort the results stream out one beat per cycle while
// the consumer takes them. No input is taken from the last beat of a batch
// until the last result of that batch has been loaded into the output
// register. The order is max heap / ascending when cfg_wdata was 0, min heap /
// descending when 1. The store has no reset; only entries of the current
// batch are read.
module heap_sorter
  import hs_pkg::*;
#(
  parameter int DEPTH = HS_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  hs_in_t  in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output hs_out_t out_data,
  input  logic    cfg_we,
  input  logic    cfg_wdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;

  hs_ctrl_t  ctrl;
  hs_flags_t flags;

  logic signed [HS_VW-1:0] mem [DEPTH];

  logic          desc_r, min_r, ph_r, ovf_r;
  logic          desc_nxt, min_nxt, ph_nxt, ovf_nxt;
  logic [CW-1:0] cnt_r, n_r, i_r, k_r;
  logic [CW-1:0] cnt_nxt, n_nxt, i_nxt, k_nxt;
  logic [AW-1:0] node_r, pick_r;
  logic [AW-1:0] node_nxt, pick_nxt;
  logic signed [HS_VW-1:0] pv_r, bv_r, rd_r;
  logic signed [HS_VW-1:0] pv_nxt, bv_nxt;
  logic          out_valid_r, out_valid_nxt;
  hs_out_t       out_data_r, out_data_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic signed [HS_VW-1:0] wdata;

  logic [IW-1:0] lc_node, rc_node, lc_pick, n_ext;
  logic [CW-1:0] im1, nm1, kp1;
  logic          in_fire, out_free, room;

  assign in_ready  = (ctrl.op == OP_COLLECT);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign lc_node = {1'b0, node_r, 1'b1};
  assign rc_node = lc_node + IW'(1);
  assign lc_pick = {1'b0, pick_r, 1'b1};
  assign n_ext   = IW'(n_r);
  assign im1     = i_r - CW'(1);
  assign nm1     = n_r - CW'(1);
  assign kp1     = k_r + CW'(1);
  assign room    = (cnt_r < CW'(DEPTH));

  always_comb begin
    flags.last_fire    = in_fire && in_data.last;
    flags.i_zero       = (i_r == '0);
    flags.n_le1        = (n_r <= CW'(1));
    flags.n_gt2        = (n_r > CW'(2));
    flags.ph_extract   = ph_r;
    flags.no_lc        = (lc_node >= n_ext);
    flags.no_rc        = (rc_node >= n_ext);
    flags.pick_eq_node = (pick_r == node_r);
    flags.has_lc_pick  = (lc_pick < n_ext);
    flags.out_free     = out_free;
    flags.k_last       = (k_r == cnt_r - CW'(1));
  end

  hs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  always_comb begin
    desc_nxt      = cfg_we ? cfg_wdata : desc_r;
    min_nxt       = min_r;
    ph_nxt        = ph_r;
    ovf_nxt       = ovf_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    node_nxt      = node_r;
    pick_nxt      = pick_r;
    pv_nxt        = pv_r;
    bv_nxt        = bv_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    we            = 1'b0;
    waddr         = '0;
    wdata         = pv_r;
    raddr         = '0;
    case (ctrl.op)
      OP_COLLECT: begin
        if (in_fire) begin
          if (room) begin
            we      = 1'b1;
            waddr   = cnt_r[AW-1:0];
            wdata   = in_data.value;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      OP_INIT: begin
        n_nxt   = cnt_r;
        i_nxt   = cnt_r >> 1;
        min_nxt = desc_r;
        ph_nxt  = 1'b0;
      end
      OP_BSTART: begin
        i_nxt    = im1;
        node_nxt = im1[AW-1:0];
        raddr    = im1[AW-1:0];
      end
      OP_SDLOAD: begin
        pv_nxt   = rd_r;
        bv_nxt   = rd_r;
        pick_nxt = node_r;
        raddr    = lc_node[AW-1:0];
      end
      OP_CMPL: begin
        if (hs_ranks_above(rd_r, bv_r, min_r)) begin
          bv_nxt   = rd_r;
          pick_nxt = lc_node[AW-1:0];
        end
        raddr = rc_node[AW-1:0];
      end
      OP_CMPR: begin
        if (hs_ranks_above(rd_r, bv_r, min_r)) begin
          bv_nxt   = rd_r;
          pick_nxt = rc_node[AW-1:0];
        end
      end
      OP_WNODE: begin
        we    = 1'b1;
        waddr = node_r;
        wdata = bv_r;
      end
      OP_SWAP: begin
        // parent value moves down; keep it for the next level
        we       = 1'b1;
        waddr    = pick_r;
        wdata    = pv_r;
        node_nxt = pick_r;
        bv_nxt   = pv_r;
        raddr    = lc_pick[AW-1:0];
      end
      OP_XRD0: begin
        raddr = '0;
      end
      OP_XRD1: begin
        bv_nxt = rd_r;
        raddr  = nm1[AW-1:0];
      end
      OP_XW0: begin
        we     = 1'b1;
        waddr  = '0;
        wdata  = rd_r;
        pv_nxt = rd_r;
      end
      OP_XW1: begin
        // old root goes to the end, heap shrinks by one
        we       = 1'b1;
        waddr    = nm1[AW-1:0];
        wdata    = bv_r;
        n_nxt    = nm1;
        node_nxt = '0;
        pick_nxt = '0;
        bv_nxt   = pv_r;
        ph_nxt   = 1'b1;
        raddr    = AW'(1);
      end
      OP_OSTART: begin
        k_nxt = '0;
        raddr = '0;
      end
      OP_OEMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.sorted_value = rd_r;
          out_data_nxt.end_of_batch = flags.k_last;
          out_data_nxt.overflow     = ovf_r;
          k_nxt                     = kp1;
          raddr                     = kp1[AW-1:0];
        end else begin
          raddr = k_r[AW-1:0];
        end
      end
      OP_ODONE: begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r      <= 1'b0;
      min_r       <= 1'b0;
      ph_r        <= 1'b0;
      ovf_r       <= 1'b0;
      cnt_r       <= '0;
      n_r         <= '0;
      i_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      desc_r      <= desc_nxt;
      min_r       <= min_nxt;
      ph_r        <= ph_nxt;
      ovf_r       <= ovf_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    pick_r     <= pick_nxt;
    pv_r       <= pv_nxt;
    bv_r       <= bv_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### hw/rtl/hs_checker.sv
// heap_sorter port checker and its bind to the top level
module hs_checker
  import hs_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input hs_in_t  in_data,
  input logic    out_valid,
  input logic    out_ready,
  input hs_out_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // a closing beat starts the sort, so input stops at once
  a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last |=> !in_ready)
    else $error("input still taken after closing beat");

  // new results are only loaded while input is closed
  a_no_result_while_collecting: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while collecting");

  // more results of the batch follow, input stays closed
  a_mid_batch_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.end_of_batch |=> !in_ready)
    else $error("input reopened before batch end");

endmodule

bind heap_sorter hs_checker u_hs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### dv/heap_sorter_checker.sv
// heap_sorter checker: predicts each sorted batch and compares the result beats
module heap_sorter_checker
  import hs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_ready,
  input  hs_in_t  in_data,
  input  logic    out_valid,
  input  logic    out_ready,
  input  hs_out_t out_data,
  input  logic    cfg_we,
  input  logic    cfg_wdata,
  output int      fail_count,
  output int      due_count
);

  localparam int MAX_REPORTS = 200;

  logic signed [HS_VW-1:0] held [HS_DEPTH];
  int      held_count;
  logic    dropped;
  logic    descending;
  hs_out_t sorted_due [$];

  function automatic void sift_down(input int size, input int node, input logic min_heap);
    int pick;
    int lc;
    int rc;
    logic signed [HS_VW-1:0] tmp;
    while (node < size) begin
      pick = node;
      lc = 2 * node + 1;
      rc = 2 * node + 2;
      // a child moves up only when strictly better than the current pick
      if (lc < size && (min_heap ? held[lc] < held[pick] : held[lc] > held[pick]))
        pick = lc;
      if (rc < size && (min_heap ? held[rc] < held[pick] : held[rc] > held[pick]))
        pick = rc;
      if (pick == node)
        break;
      tmp = held[node];
      held[node] = held[pick];
      held[pick] = tmp;
      node = pick;
    end
  endfunction

  function automatic void heap_sort_held(input int n, input logic min_heap);
    logic signed [HS_VW-1:0] tmp;
    for (int i = n / 2; i > 0; i--)
      sift_down(n, i - 1, min_heap);
    for (int i = n; i > 1; i--) begin
      tmp = held[0];
      held[0] = held[i - 1];
      held[i - 1] = tmp;
      sift_down(i - 1, 0, min_heap);
    end
  endfunction

  task automatic take_value(input hs_in_t beat);
    hs_out_t res;
    if (held_count < HS_DEPTH) begin
      held[held_count] = beat.value;
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (beat.last) begin
      heap_sort_held(held_count, descending);
      for (int k = 0; k < held_count; k++) begin
        res.sorted_value = held[k];
        res.end_of_batch = (k == held_count - 1);
        res.overflow     = dropped;
        sorted_due.push_back(res);
      end
      held_count = 0;
      dropped    = 1'b0;
    end
  endtask

  task automatic check_result(input hs_out_t got);
    hs_out_t want;
    if (sorted_due.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $error("result beat with nothing expected: sorted_value %0d", got.sorted_value);
    end else begin
      want = sorted_due.pop_front();
      if (got.sorted_value !== want.sorted_value) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $error("sorted_value: expected %0d, got %0d", want.sorted_value, got.sorted_value);
      end
      if (got.end_of_batch !== want.end_of_batch) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $error("end_of_batch: expected %0b, got %0b", want.end_of_batch, got.end_of_batch);
      end
      if (got.overflow !== want.overflow) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      dropped    = 1'b0;
      descending = 1'b0;
      fail_count = 0;
      sorted_due.delete();
    end else begin
      // results first: a beat leaving now never belongs to a batch closing now
      if (out_valid && out_ready)
        check_result(out_data);
      if (in_valid && in_ready)
        take_value(in_data);
      if (cfg_we)
        descending = cfg_wdata;
    end
    due_count = sorted_due.size();
  end

endmodule

### dv/heap_sorter_tb.sv
// heap_sorter testbench top: clock, reset, stimulus, receiver stalls and verdict
module heap_sorter_tb
  import hs_pkg::*;
();

  localparam int QUIET_LIMIT   = 40000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES   = 100;

  typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LIGHT} stall_mode_t;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_ready;
  hs_in_t  in_data   = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  hs_out_t out_data;
  logic    cfg_we    = 1'b0;
  logic    cfg_wdata = 1'b0;
  int      fail_count;
  int      due_count;
  int      quiet_cycles = 0;
  int      burst_left   = 0;
  bit      hold_req     = 1'b0;
  logic signed [HS_VW-1:0] batch_q [$];

  heap_sorter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  heap_sorter_checker sort_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver: random stall patterns, each held for a random span, plus one long hold-off
  initial begin : receiver
    stall_mode_t mode;
    int span;
    bit hold_done;
    mode = STALL_NONE;
    span = 0;
    hold_done = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (span == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        span = $urandom_range(8, 80);
      end
      span--;
      case (mode)
        STALL_NONE:  out_ready <= 1'b1;
        STALL_HALF:  out_ready <= ($urandom_range(0, 1) == 0);
        STALL_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
        default:     out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic logic signed [HS_VW-1:0] random_value();
    logic signed [HS_VW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = ($urandom_range(0, 1) == 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
      1, 2: begin
        // narrow range so batches carry repeated values
        v = $urandom_range(0, 8);
        v = v - 4;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // valid stays up after the beat so a following beat can go out back to back
  task automatic offer_value(input logic signed [HS_VW-1:0] v, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{value: v, last: is_last};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic offer_batch();
    foreach (batch_q[k])
      offer_value(batch_q[k], k == batch_q.size() - 1);
  endtask

  task automatic fill_random(input int n);
    batch_q = {};
    repeat (n) batch_q.push_back(random_value());
  endtask

  task automatic wait_sorted_out();
    in_valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_order(input logic descending);
    wait_sorted_out();
    cfg_we    <= 1'b1;
    cfg_wdata <= descending;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes in both orders, repeated values, a one-value batch and a two-value batch
    write_order(1'b0);
    batch_q = '{32'sh8000_0000};
    offer_batch();
    batch_q = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1, 32'sh7fff_ffff};
    offer_batch();
    batch_q = '{32'sd3, 32'sd3, 32'sd3};
    offer_batch();
    write_order(1'b1);
    batch_q = '{32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 32'sd0, 32'sd5};
    offer_batch();
    batch_q = '{32'sd2, -32'sd2};
    offer_batch();
    // order flips while a batch is half collected: the order at the last beat counts
    offer_value(32'sd9, 1'b0);
    offer_value(-32'sd9, 1'b0);
    offer_value(32'sd4, 1'b0);
    write_order(1'b0);
    offer_value(-32'sd4, 1'b1);

    for (int b = 0; b < 22; b++) begin
      if ($urandom_range(0, 2) == 0)
        write_order(1'($urandom_range(0, 1)));
      if (b == 5) begin
        // long receiver hold-off: the second batch backs up behind the first
        hold_req = 1'b1;
        fill_random(4);
        offer_batch();
        fill_random(5);
        offer_batch();
        wait_sorted_out();
      end else begin
        // one batch past the store depth, so a plain beat and the last beat are dropped
        n = (b == 11) ? HS_DEPTH + 2 : $urandom_range(1, 8);
        fill_random(n);
        offer_batch();
      end
    end

    wait_sorted_out();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && due_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### heap_sorter.f
hw/rtl/hs_pkg.sv
hw/rtl/hs_seq.sv
hw/rtl/heap_sorter.sv
hw/rtl/hs_checker.sv
dv/heap_sorter_checker.sv
dv/heap_sorter_tb.sv
